// ===== design/rgbbmp_pkg.sv =====
package rgbbmp_pkg;

  // width of a size field; the configuration registers are this wide
  localparam int SZ_W = 11;

  // configuration register indexes
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [SZ_W-1:0] WIDTH_RST  = 11'd320;
  localparam logic [SZ_W-1:0] HEIGHT_RST = 11'd240;

  // bmp header constants
  localparam int HDR_BYTES       = 54;
  localparam int INFO_HDR_SIZE   = 40;
  localparam int BMP_BPP         = 24;
  localparam int BMP_PLANES      = 1;
  localparam int BMP_PPM         = 2835;
  localparam logic [7:0] SIG_B   = 8'h42;
  localparam logic [7:0] SIG_M   = 8'h4d;

  // byte index within one item's run
  localparam int IDX_W = 6;

  // command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = 1;

  typedef enum logic {
    CMD_HDR = 1'b0,
    CMD_PIX = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [23:0]     bgr;        // blue in the low byte, then green, then red
    logic [1:0]      npad;       // zero bytes after the pixel, 0 unless row end
    logic            frame_end;
    logic [SZ_W-1:0] w;
    logic [SZ_W-1:0] h;
  } cmd_t;

endpackage

// ===== design/rgbbmp_front.sv =====
module rgbbmp_front import rgbbmp_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [SZ_W-1:0] image_width,
  input  logic [SZ_W-1:0] image_height,
  input  logic            acc,
  input  logic            mode,
  input  logic [15:0]     pixel,
  output logic            push,
  output cmd_t            push_cmd
);

  localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MW   = (CW > RW) ? CW : RW;
  localparam int CMPW = ((MW > SZ_W) ? MW : SZ_W) + 1;

  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic            active_r, active_nxt;
  logic [SZ_W-1:0] w, h;
  logic            row_end, frame_end;
  logic [4:0]      red, blue;
  logic [5:0]      green;

  // saturate sizes to 1..max
  always_comb begin
    if (image_width == '0) begin
      w = SZ_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = SZ_W'(MAX_WIDTH);
    end else begin
      w = image_width;
    end
    if (image_height == '0) begin
      h = SZ_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h = SZ_W'(MAX_HEIGHT);
    end else begin
      h = image_height;
    end
  end

  assign row_end   = (CMPW'(col_r) + CMPW'(1)) >= CMPW'(w);
  assign frame_end = row_end && ((CMPW'(row_r) + CMPW'(1)) >= CMPW'(h));

  assign red   = pixel[15:11];
  assign green = pixel[10:5];
  assign blue  = pixel[4:0];

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    active_nxt = active_r;
    push       = 1'b0;
    push_cmd.kind      = CMD_HDR;
    push_cmd.bgr       = {red, red[4:2], green, green[5:4], blue, blue[4:2]};
    push_cmd.npad      = row_end ? w[1:0] : 2'd0;
    push_cmd.frame_end = frame_end;
    push_cmd.w         = w;
    push_cmd.h         = h;
    if (acc) begin
      if (mode == 1'b0) begin
        push       = 1'b1;
        col_nxt    = '0;
        row_nxt    = '0;
        active_nxt = 1'b1;
      end else if (active_r) begin
        push          = 1'b1;
        push_cmd.kind = CMD_PIX;
        if (row_end) begin
          col_nxt = '0;
          if (frame_end) begin
            row_nxt    = '0;
            active_nxt = 1'b0;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      active_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== design/rgbbmp_fifo.sv =====
module rgbbmp_fifo import rgbbmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_PW-1:0] wp_r, rp_r;
  logic [Q_PW:0]   cnt_r;

  assign full    = (cnt_r == (Q_PW+1)'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + Q_PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + Q_PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (Q_PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (Q_PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== design/rgbbmp_back.sv =====
module rgbbmp_back import rgbbmp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_done
);

  cmd_t             cmd_r;
  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      img_r, fsize_r;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r;
  logic             olast_r, odone_r;
  logic             emit, last;
  logic [IDX_W-1:0] last_idx;
  logic [7:0]       cur_byte;
  logic [12:0]      line_len;
  logic [31:0]      wext, hext;

  assign wext     = 32'(cmd_r.w);
  assign hext     = 32'(cmd_r.h);
  // padded row length: the pad count equals width mod 4
  assign line_len = 13'({cmd_r.w, 1'b0}) + 13'(cmd_r.w) + 13'(cmd_r.w[1:0]);

  assign last_idx = (cmd_r.kind == CMD_HDR) ? IDX_W'(HDR_BYTES - 1)
                                            : IDX_W'(2) + IDX_W'(cmd_r.npad);
  assign emit = busy_r && (!ovalid_r || out_ready);
  assign last = (idx_r == last_idx);
  assign pop  = q_valid && (!busy_r || (emit && last));

  // header layout, little-endian fields
  always_comb begin
    cur_byte = 8'h00;
    if (cmd_r.kind == CMD_PIX) begin
      case (idx_r)
        6'd0:    cur_byte = cmd_r.bgr[7:0];
        6'd1:    cur_byte = cmd_r.bgr[15:8];
        6'd2:    cur_byte = cmd_r.bgr[23:16];
        default: cur_byte = 8'h00;
      endcase
    end else begin
      case (idx_r)
        6'd0:    cur_byte = SIG_B;
        6'd1:    cur_byte = SIG_M;
        6'd2:    cur_byte = fsize_r[7:0];
        6'd3:    cur_byte = fsize_r[15:8];
        6'd4:    cur_byte = fsize_r[23:16];
        6'd5:    cur_byte = fsize_r[31:24];
        6'd10:   cur_byte = 8'(HDR_BYTES);
        6'd14:   cur_byte = 8'(INFO_HDR_SIZE);
        6'd18:   cur_byte = wext[7:0];
        6'd19:   cur_byte = wext[15:8];
        6'd22:   cur_byte = hext[7:0];
        6'd23:   cur_byte = hext[15:8];
        6'd26:   cur_byte = 8'(BMP_PLANES);
        6'd28:   cur_byte = 8'(BMP_BPP);
        6'd34:   cur_byte = img_r[7:0];
        6'd35:   cur_byte = img_r[15:8];
        6'd36:   cur_byte = img_r[23:16];
        6'd37:   cur_byte = img_r[31:24];
        6'd38:   cur_byte = 8'(BMP_PPM & 255);
        6'd39:   cur_byte = 8'(BMP_PPM >> 8);
        6'd42:   cur_byte = 8'(BMP_PPM & 255);
        6'd43:   cur_byte = 8'(BMP_PPM >> 8);
        default: cur_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (emit) begin
      ovalid_nxt = 1'b1;
      idx_nxt    = idx_r + IDX_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  // image size is registered from the loaded command, file size from image size;
  // neither is read before header byte two
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_cmd;
    end
    img_r   <= 32'(line_len) * hext;
    fsize_r <= img_r + 32'(HDR_BYTES);
    if (emit) begin
      obyte_r <= cur_byte;
      olast_r <= last;
      odone_r <= last && (cmd_r.kind == CMD_PIX) && cmd_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
  assign out_done  = odone_r;

endmodule

// ===== design/rgb565_to_bmp24_stream_top.sv =====
// path: an accepted item passes the command queue and the back's command register before
// its first byte is registered; throughput: one output byte per cycle while out_tready
// is high and items are queued; a pixel gives 3 bytes, 3 to 6 at row end with padding,
// a start item 54 for the header; reset: synchronous active-low rst_n clears counters,
// frame flag, command queue and output valid; width and height return to 320 and 240
module rgb565_to_bmp24_stream_top import rgbbmp_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [SZ_W-1:0]   cfg_wdata,
  // input items
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // pixel [15:0]
  input  logic [0:0]        in_tuser,   // mode [0]
  // result items
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // out_byte [7:0]
  output logic              out_tlast,  // last byte of this item's run
  output logic [0:0]        out_tuser   // frame_done [0]
);

  logic [SZ_W-1:0] width_r, height_r;
  logic            acc;
  logic            push, full, q_valid, pop;
  cmd_t            push_cmd, q_cmd;

  // configuration registers, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front side keeps taking items while the queue has room, even if the
  // output register is still holding a byte
  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  // front: counters, frame flag, classification and pixel widening
  rgbbmp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .acc          (acc),
    .mode         (in_tuser[0]),
    .pixel        (in_tdata),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // two-entry command queue between front and back
  rgbbmp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  // back: byte sequencer for header and pixel runs, registered output
  rgbbmp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_done  (out_tuser[0])
  );

endmodule
